### rtl/core/ilir_pkg.sv
// Package for the indexed list block: sizes, operation and status codes,
// and the request, response, state and command types used by the modules.
// Depends on nothing.
package ilir_pkg;

    // List geometry.
    localparam int CAPACITY    = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int INDEX_W     = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int WORD_W      = 32;
    localparam int CMP_W       = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Operation codes carried in a request.
    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_PREPEND = 2'd1,
        OP_POP     = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    // Status codes carried in a response.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // Request transaction payload.
    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  value;
        logic [INDEX_W-1:0]        index;
    } req_t;

    // Response transaction payload.
    typedef struct packed {
        logic signed [WORD_W-1:0]  removed_value;
        status_t                   status;
        logic [COUNT_OUT_W-1:0]    count;
    } rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

### rtl/core/indexed_list_insert_remove_top.sv
// Indexed list top level: bounded ordered list with append, prepend, pop
// and remove-at-index. A request is captured in the capture state, executed in
// the execute state, and its response is held valid in the hand-off state until
// taken; a new request is accepted only after the hand-off, one at a time.
// Reset clears the fill count and controller; entry cells are not reset.
// Depends on ilir_pkg, ilir_ctrl and ilir_dp.
module indexed_list_insert_remove_top
    import ilir_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output rsp_t  out_data
);

    cmd_t cmd;

    // Transaction sequencing.
    ilir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // List storage and operation logic.
    ilir_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

### rtl/core/ilir_ctrl.sv
// Controller for the indexed list: sequences capture, execution and
// response hand-off of one transaction at a time. Depends on ilir_pkg.
module ilir_ctrl
    import ilir_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/ilir_dp.sv
// Datapath for the indexed list: request register, the row of entry cells
// that shift in parallel, the fill count and the response register.
// Depends on ilir_pkg.
module ilir_dp
    import ilir_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  req_t  in_data,
    output rsp_t  out_data
);

    req_t                      req_reg;
    req_t                      req_next;
    logic signed [WORD_W-1:0]  entries_reg [CAPACITY];
    logic signed [WORD_W-1:0]  entries_next [CAPACITY];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;

    logic signed [WORD_W-1:0]  up_arr [CAPACITY];
    logic signed [WORD_W-1:0]  down_arr [CAPACITY];
    logic [CMP_W-1:0]          rm_pos;
    logic [ADDR_W-1:0]         rm_addr;
    logic                      full;

    // Capture the request when the controller accepts a transaction.
    always_comb
    begin
        req_next = req_reg;
        if (cmd.load)
        begin
            req_next = in_data;
        end
    end

    // Neighbor views of the cells: shifted up for prepend, down for removal.
    always_comb
    begin
        up_arr[0]            = req_reg.value;
        down_arr[CAPACITY-1] = entries_reg[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
        begin
            up_arr[i]       = entries_reg[i-1];
            down_arr[i-1]   = entries_reg[i];
        end
    end

    // Removal position: the head for a pop, the requested index otherwise.
    always_comb
    begin
        if (req_reg.op == OP_POP)
        begin
            rm_pos = '0;
        end
        else
        begin
            rm_pos = CMP_W'(req_reg.index);
        end
        rm_addr = rm_pos[ADDR_W-1:0];
        full    = (count_reg == CNT_W'(CAPACITY));
    end

    // Execute the operation on the cells and form the response.
    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        rsp_next     = rsp_reg;
        if (cmd.exec)
        begin
            rsp_next.removed_value = '0;
            rsp_next.status        = STAT_OK;
            case (req_reg.op)
                OP_APPEND:
                begin
                    if (full)
                    begin
                        rsp_next.status = STAT_FULL;
                    end
                    else
                    begin
                        entries_next[count_reg[ADDR_W-1:0]] = req_reg.value;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_PREPEND:
                begin
                    if (full)
                    begin
                        rsp_next.status = STAT_FULL;
                    end
                    else
                    begin
                        entries_next = up_arr;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                OP_POP, OP_REMOVE:
                begin
                    if (rm_pos >= CMP_W'(count_reg))
                    begin
                        if (req_reg.op == OP_POP)
                        begin
                            rsp_next.status = STAT_EMPTY;
                        end
                        else
                        begin
                            rsp_next.status = STAT_RANGE;
                        end
                    end
                    else
                    begin
                        rsp_next.removed_value = entries_reg[rm_addr];
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (ADDR_W'(i) >= rm_addr)
                            begin
                                entries_next[i] = down_arr[i];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    rsp_next.status = STAT_OK;
                end
            endcase
            rsp_next.count = COUNT_OUT_W'(count_next);
        end
    end

    // Fill count is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        entries_reg <= entries_next;
        rsp_reg     <= rsp_next;
    end

    assign out_data = rsp_reg;

endmodule
